FILE: hdl/gdf_pkg.sv
package gdf_pkg;

  localparam int ValueW       = 64;
  localparam int CharW        = 8;
  localparam int DigitW       = 4;
  localparam int MaxDigitsDef = 20;
  localparam int CfgIndexW    = 2;

  localparam logic [CfgIndexW-1:0] CFG_SEPARATOR   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_SIGNED_MODE = 2'd1;

  localparam logic [CharW-1:0] CharZero     = 8'h30;
  localparam logic [CharW-1:0] CharMinus    = 8'h2D;
  localparam logic [CharW-1:0] SeparatorRst = 8'd44;

  // Per-cycle control shared by every cell of the digit chain
  typedef struct packed {
    logic clear;   // start of a new item
    logic dabble;  // add-3 and shift one binary bit in
    logic shift;   // move digits one cell toward the top
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

FILE: hdl/gdf_digit_cell.sv
module gdf_digit_cell (
  input  logic                      clk,
  input  gdf_pkg::cell_ctl_t        ctl,
  input  logic                      carry_in,
  input  logic [gdf_pkg::DigitW-1:0] digit_in,
  output logic                      carry_out,
  output logic [gdf_pkg::DigitW-1:0] digit
);
  import gdf_pkg::*;

  logic [DigitW-1:0] adj;
  logic [DigitW-1:0] digit_next;

  // a digit of 5 or more overflows into the next decade after doubling
  assign adj       = (digit >= DigitW'(5)) ? digit + DigitW'(3) : digit;
  assign carry_out = adj[DigitW-1];

  always_comb begin
    priority if (ctl.clear) begin
      digit_next = '0;
    end else if (ctl.dabble) begin
      digit_next = {adj[DigitW-2:0], carry_in};
    end else if (ctl.shift) begin
      digit_next = digit_in;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

FILE: hdl/grouped_decimal_formatter.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   value[63:0]
// out      out_valid / out_stall character[7:0], last
// cfg      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[7:0]
//
// One item at a time: the accept, a 64-step shift-add-3 pass through the
// digit chain, then a walk over the MAX_DIGITS digit positions (leading
// zeros are dropped without output) plus the minus sign and every separator,
// each sent as a character of its own.
// rst is synchronous; it resets control and the config registers (comma, signed).
// out_stall, while out_valid is high, holds the character register and freezes the emit sequence.
module grouped_decimal_formatter #(
  parameter int MAX_DIGITS = gdf_pkg::MaxDigitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gdf_pkg::ValueW-1:0]    value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gdf_pkg::CharW-1:0]     character,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gdf_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gdf_pkg::CharW-1:0]     cfg_data
);
  import gdf_pkg::*;

  localparam int PosW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BitCntW = $clog2(ValueW);
  localparam logic [PosW-1:0] PosInit = PosW'(MAX_DIGITS - 1);
  localparam logic [1:0] Mod3Init = 2'((MAX_DIGITS - 1) % 3);

  state_t state;
  logic [CharW-1:0]   group_separator;
  logic               signed_mode;
  logic [ValueW-1:0]  mag;
  logic [BitCntW-1:0] bit_cnt;
  logic [PosW-1:0]    pos;
  logic [1:0]         mod3;
  logic               started;
  logic               sign_pending;
  logic               sep_pending;
  logic               truncated;

  cell_ctl_t          ctl;
  logic               carry [MAX_DIGITS];
  logic               top_carry;
  logic [DigitW-1:0]  digits [MAX_DIGITS];
  logic [DigitW-1:0]  top_digit;

  logic in_accept;
  logic load_ok;
  logic skip;
  logic digit_step;
  logic load_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = !out_valid || !out_stall;
  assign top_digit = digits[MAX_DIGITS-1];

  // leading zeros are dropped unless digits fell off the top of the chain;
  // the digit at position 0 always prints
  assign skip       = (state == S_EMIT) && load_ok && !sign_pending && !sep_pending
                      && !started && !truncated && (top_digit == '0) && (pos != '0);
  assign digit_step = (state == S_EMIT) && load_ok && !sign_pending && !sep_pending;
  assign load_last  = digit_step && !skip && (pos == '0);

  assign ctl.clear  = in_accept;
  assign ctl.dabble = (state == S_CONV);
  assign ctl.shift  = digit_step;

  generate
    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign carry[0] = mag[ValueW-1];
      end
      if (i < MAX_DIGITS - 1) begin : g_mid
        gdf_digit_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .carry_in  (carry[i]),
          .digit_in  ((i == 0) ? DigitW'(0) : digits[(i == 0) ? 0 : i-1]),
          .carry_out (carry[(i < MAX_DIGITS - 1) ? i+1 : i]),
          .digit     (digits[i])
        );
      end else begin : g_top
        // a carry out of the top cell means higher digits are dropped
        gdf_digit_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .carry_in  (carry[i]),
          .digit_in  ((i == 0) ? DigitW'(0) : digits[(i == 0) ? 0 : i-1]),
          .carry_out (top_carry),
          .digit     (digits[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      group_separator <= SeparatorRst;
      signed_mode     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEPARATOR:   group_separator <= cfg_data;
        CFG_SIGNED_MODE: signed_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      sign_pending <= 1'b0;
      sep_pending  <= 1'b0;
      started      <= 1'b0;
      truncated    <= 1'b0;
      bit_cnt      <= '0;
      pos          <= '0;
      mod3         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state        <= S_CONV;
            bit_cnt      <= BitCntW'(ValueW - 1);
            pos          <= PosInit;
            mod3         <= Mod3Init;
            started      <= 1'b0;
            truncated    <= 1'b0;
            sep_pending  <= 1'b0;
            sign_pending <= signed_mode && value[ValueW-1];
          end
        end
        S_CONV: begin
          bit_cnt <= bit_cnt - BitCntW'(1);
          if (top_carry) begin
            truncated <= 1'b1;
          end
          if (bit_cnt == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            priority if (sign_pending) begin
              sign_pending <= 1'b0;
            end else if (sep_pending) begin
              sep_pending <= 1'b0;
            end else begin
              if (!skip) begin
                started <= 1'b1;
              end
              if (pos == '0) begin
                state <= S_IDLE;
              end else begin
                sep_pending <= !skip && (mod3 == 2'd0);
                pos         <= pos - PosW'(1);
                mod3        <= (mod3 == 2'd0) ? 2'd2 : mod3 - 2'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load_ok) begin
        out_valid <= (state == S_EMIT) && !skip;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mag <= (signed_mode && value[ValueW-1]) ? ~value + ValueW'(1) : value;
    end else if (state == S_CONV) begin
      mag <= {mag[ValueW-2:0], 1'b0};
    end
    if (load_ok && state == S_EMIT && !skip) begin
      priority if (sign_pending) begin
        character <= CharMinus;
        last      <= 1'b0;
      end else if (sep_pending) begin
        character <= group_separator;
        last      <= 1'b0;
      end else begin
        character <= CharZero + CharW'(top_digit);
        last      <= load_last;
      end
    end
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_CONV) && (bit_cnt == BitCntW'(ValueW - 1)))
    else $error("accepted item did not start conversion");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (state == S_IDLE) && out_valid && last)
    else $error("final character did not end the item");

  a_sep_after_sign: assert property (@(posedge clk) disable iff (rst)
    sep_pending |-> !sign_pending && started)
    else $error("separator pending before any digit");

  a_conv_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) && $past(state == S_CONV) |-> !$rose(out_valid))
    else $error("character issued during conversion");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import gdf_pkg::*;

  localparam int DigitSlots = MaxDigitsDef;
  localparam int GroupSize  = 3;
  localparam int Radix      = 10;

  // the index field is wider than the register map
  localparam logic [CfgIndexW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgUnusedHi = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } glyph_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ValueW-1:0]    value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CharW-1:0]     character;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CharW-1:0]     cfg_data = '0;

  // shadow of the block's registers
  logic [CharW-1:0] separator_shadow = SeparatorRst;
  logic             signed_shadow = 1'b1;

  logic [ValueW-1:0] pending_values[$];
  glyph_t            expected_text[$];
  glyph_t            got_glyph;
  glyph_t            want_glyph;

  bit idle_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int error_count = 0;
  int values_sent = 0;
  int chars_checked = 0;
  int reg_writes = 0;

  grouped_decimal_formatter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  // Decimal text with grouping, most significant character first
  task automatic predict_text(input logic [ValueW-1:0] v);
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digits[DigitSlots];
    int                n;
    glyph_t            g;
    neg = signed_shadow && v[ValueW-1];
    mag = neg ? (~v + 64'd1) : v;
    n = 0;
    do begin
      digits[n] = DigitW'(mag % Radix);
      mag = mag / Radix;
      n++;
    end while (mag != 0 && n < DigitSlots);
    if (neg) begin
      g.ch = CharMinus;
      g.fin = 1'b0;
      expected_text.push_back(g);
    end
    for (int i = n - 1; i >= 0; i--) begin
      g.ch = CharZero + CharW'(digits[i]);
      g.fin = (i == 0);
      expected_text.push_back(g);
      if (i > 0 && i % GroupSize == 0) begin
        g.ch = separator_shadow;
        g.fin = 1'b0;
        expected_text.push_back(g);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(value);
        values_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          in_valid <= 1'b1;
          value <= pending_values.pop_front();
          if (idle_on && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_glyph.ch = character;
        got_glyph.fin = last;
        if (expected_text.size() == 0) begin
          flag_error($sformatf("unexpected char %02h last %0b", character, last));
        end else begin
          want_glyph = expected_text.pop_front();
          if (got_glyph.ch !== want_glyph.ch || got_glyph.fin !== want_glyph.fin)
            flag_error($sformatf("char %0d: expected %02h last %0b, got %02h last %0b",
                                 chars_checked, want_glyph.ch, want_glyph.fin,
                                 got_glyph.ch, got_glyph.fin));
        end
        chars_checked++;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CharW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SEPARATOR:   separator_shadow = data;
      CFG_SIGNED_MODE: signed_shadow = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // sender holds off until the block has nothing left to say
  task automatic wait_idle();
    @(negedge clk);
    while (pending_values.size() != 0 || in_valid || expected_text.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] p;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      2: begin
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * Radix;
        v = p - 64'd1 + ValueW'($urandom_range(0, 2));
      end
      default: v = 64'd0 - ({$urandom, $urandom} >> $urandom_range(1, 63));
    endcase
    return v;
  endfunction

  task automatic random_phase(input logic [CharW-1:0] sep, input logic sgn, input int count);
    write_reg(CFG_SEPARATOR, sep);
    write_reg(CFG_SIGNED_MODE, {7'd0, sgn});
    repeat (count) pending_values.push_back(pick_value());
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: signed, comma separator
    pending_values = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999, 64'd1000,
                       64'd999999, 64'd1000000, 64'h7FFF_FFFF_FFFF_FFFF,
                       64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'd0 - 64'd1000, 64'd0 - 64'd999999};
    wait_idle();

    // upper data bits of the mode register are dropped; unused indexes do nothing
    write_reg(CFG_SIGNED_MODE, 8'hFE);
    write_reg(CFG_SEPARATOR, 8'h5F);
    write_reg(CfgUnusedLo, 8'h00);
    write_reg(CfgUnusedHi, 8'hFF);
    pending_values = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'd10000000000000000000, 64'd0, 64'd1234};
    wait_idle();

    random_phase(8'h00, 1'b1, 33);
    random_phase(8'hFF, 1'b0, 33);
    random_phase(CharW'($urandom_range(0, 255)), 1'b1, 33);
    random_phase(CharW'($urandom_range(0, 255)), 1'b0, 33);
    random_phase(CharW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 33);
    idle_on = 1'b0;
    random_phase(CharW'($urandom_range(0, 255)), 1'b1, 33);

    repeat (120) @(posedge clk);
    if (expected_text.size() != 0)
      flag_error($sformatf("%0d characters never arrived", expected_text.size()));
    $display("formatted %0d values across %0d register writes", values_sent, reg_writes);
    $display("%0d characters compared, %0d mismatches", chars_checked, error_count);
    if (error_count == 0) begin
      $display("grouped_decimal_formatter verification clean");
    end else begin
      $display("grouped_decimal_formatter verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("grouped_decimal_formatter verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/gdf_pkg.sv
hdl/gdf_digit_cell.sv
hdl/grouped_decimal_formatter.sv
sim/tb.sv
